FILE: hw/rtl/sst_pkg.sv
package sst_pkg;

    localparam int MAX_SIDE_TILES = 16;
    localparam int SIDE_W         = 5;
    localparam int SHAPE_COUNT    = 12;
    localparam int SHAPE_IDX_W    = 4;
    localparam int PIECE_LIMIT    = 64;
    localparam int CNT_W          = 7;

    typedef logic [SIDE_W-1:0]      side_t;
    typedef logic [SHAPE_IDX_W-1:0] shape_idx_t;

    function automatic logic [3:0] shape_wid(input shape_idx_t idx);
        logic [3:0] w;
        begin
            case (idx)
                4'd0, 4'd1:                w = 4'd8;
                4'd2, 4'd3, 4'd4, 4'd5:    w = 4'd4;
                4'd6, 4'd7, 4'd8:          w = 4'd2;
                default:                   w = 4'd1;
            endcase
            return w;
        end
    endfunction

    function automatic logic [3:0] shape_hgt(input shape_idx_t idx);
        logic [3:0] h;
        begin
            case (idx)
                4'd0, 4'd2:                h = 4'd8;
                4'd1, 4'd3, 4'd6, 4'd9:    h = 4'd4;
                4'd4, 4'd7, 4'd10:         h = 4'd2;
                default:                   h = 4'd1;
            endcase
            return h;
        end
    endfunction

    // first shape in list order that fits w by h, else the smallest
    function automatic shape_idx_t first_fit(input side_t w, input side_t h);
        shape_idx_t sel;
        logic       found;
        begin
            sel   = shape_idx_t'(SHAPE_COUNT - 1);
            found = 1'b0;
            for (int i = 0; i < SHAPE_COUNT; i++)
            begin
                if (!found && ({1'b0, shape_wid(shape_idx_t'(i))} <= w)
                    && ({1'b0, shape_hgt(shape_idx_t'(i))} <= h))
                begin
                    sel   = shape_idx_t'(i);
                    found = 1'b1;
                end
            end
            return sel;
        end
    endfunction

endpackage

FILE: hw/rtl/sprite_shape_rect_tiler.sv
// after start: band state, then piece state, which registers the first piece's strobe
// throughput: one piece per cycle from a shared shape selector, except in band states;
//   busy is high while the sequencer is out of the idle state
// a window with a zero side is ignored and gives no piece; busy does not rise
// the receiver cannot stall: each piece is shown for exactly one cycle with strobe high
// reset (rst_n low, asynchronous) clears the sequencer and the strobe; no piece is pending
module sprite_shape_rect_tiler
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] width_tiles,
    input  logic [4:0] height_tiles,
    output logic       strobe,
    output logic [3:0] piece_x,
    output logic [3:0] piece_y,
    output logic [3:0] shape_index,
    output logic [3:0] shape_width,
    output logic [3:0] shape_height,
    output logic       last,
    output logic       overlap_error
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BAND  = 2'd1;
    localparam logic [1:0] ST_PIECE = 2'd2;

    localparam sst_pkg::side_t SIDE_MAX = sst_pkg::side_t'(sst_pkg::MAX_SIDE_TILES);

    logic [1:0]                  state_reg, state_next;
    logic [sst_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    sst_pkg::side_t              w_reg, w_next;
    sst_pkg::side_t              rem_h_reg, rem_h_next;
    sst_pkg::side_t              band_y_reg, band_y_next;
    sst_pkg::side_t              bh_reg, bh_next;
    sst_pkg::side_t              cx_reg, cx_next, cy_reg, cy_next;
    sst_pkg::side_t              cw_reg, cw_next, ch_reg, ch_next;
    sst_pkg::side_t              px_reg, px_next, py_reg, py_next;
    sst_pkg::side_t              pw_reg, pw_next, ph_reg, ph_next;

    logic                        strobe_reg, strobe_next;
    logic [3:0]                  x_reg, x_next, y_reg, y_next;
    sst_pkg::shape_idx_t         s_reg, s_next;
    logic                        last_reg, last_next;
    logic                        err_reg, err_next;

    sst_pkg::side_t              w_sat, h_sat;
    sst_pkg::shape_idx_t         fit_idx;
    sst_pkg::side_t              fit_w, fit_h;
    sst_pkg::side_t              fit_a, fit_b;
    sst_pkg::side_t              band_h;
    sst_pkg::side_t              rem_after;
    logic                        split, down, pend_new, run_end;
    sst_pkg::side_t              npx, npy, npw, nph;

    assign w_sat = (width_tiles > SIDE_MAX) ? SIDE_MAX : width_tiles;
    assign h_sat = (height_tiles > SIDE_MAX) ? SIDE_MAX : height_tiles;

    // shared shape selector: band height in the band state, piece shape otherwise
    always_comb
    begin
        if (state_reg == ST_BAND)
        begin
            fit_a = w_reg;
            fit_b = rem_h_reg;
        end
        else
        begin
            fit_a = cw_reg;
            fit_b = ch_reg;
        end
    end

    assign fit_idx = sst_pkg::first_fit(fit_a, fit_b);
    assign fit_w   = {1'b0, sst_pkg::shape_wid(fit_idx)};
    assign fit_h   = {1'b0, sst_pkg::shape_hgt(fit_idx)};
    assign band_h  = fit_h;

    assign split     = cw_reg > fit_w;
    assign down      = ch_reg > fit_h;
    assign pend_new  = pend_reg | split;
    assign npx       = split ? (cx_reg + fit_w) : px_reg;
    assign npy       = split ? cy_reg : py_reg;
    assign npw       = split ? (cw_reg - fit_w) : pw_reg;
    assign nph       = split ? ch_reg : ph_reg;
    assign rem_after = rem_h_reg - bh_reg;
    assign run_end   = (split && pend_reg)
                    || (cnt_reg == sst_pkg::CNT_W'(sst_pkg::PIECE_LIMIT - 1))
                    || (!down && !pend_new && (rem_after == '0));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        w_next      = w_reg;
        rem_h_next  = rem_h_reg;
        band_y_next = band_y_reg;
        bh_next     = bh_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cw_next     = cw_reg;
        ch_next     = ch_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pw_next     = pw_reg;
        ph_next     = ph_reg;
        strobe_next = 1'b0;
        x_next      = x_reg;
        y_next      = y_reg;
        s_next      = s_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (w_sat != '0) && (h_sat != '0))
                begin
                    w_next      = w_sat;
                    rem_h_next  = h_sat;
                    band_y_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_BAND;
                end
            end
            ST_BAND:
            begin
                bh_next    = band_h;
                cx_next    = '0;
                cy_next    = band_y_reg;
                cw_next    = w_reg;
                ch_next    = band_h;
                pend_next  = 1'b0;
                state_next = ST_PIECE;
            end
            ST_PIECE:
            begin
                strobe_next = 1'b1;
                x_next      = cx_reg[3:0];
                y_next      = cy_reg[3:0];
                s_next      = fit_idx;
                last_next   = run_end;
                err_next    = split && pend_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (run_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (down)
                begin
                    cy_next   = cy_reg + fit_h;
                    ch_next   = ch_reg - fit_h;
                    pend_next = pend_new;
                    px_next   = npx;
                    py_next   = npy;
                    pw_next   = npw;
                    ph_next   = nph;
                end
                else if (pend_new)
                begin
                    cx_next   = npx;
                    cy_next   = npy;
                    cw_next   = npw;
                    ch_next   = nph;
                    pend_next = 1'b0;
                end
                else
                begin
                    band_y_next = band_y_reg + bh_reg;
                    rem_h_next  = rem_after;
                    state_next  = ST_BAND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        rem_h_reg  <= rem_h_next;
        band_y_reg <= band_y_next;
        bh_reg     <= bh_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cw_reg     <= cw_next;
        ch_reg     <= ch_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        s_reg      <= s_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign piece_x       = x_reg;
    assign piece_y       = y_reg;
    assign shape_index   = s_reg;
    assign shape_width   = sst_pkg::shape_wid(s_reg);
    assign shape_height  = sst_pkg::shape_hgt(s_reg);
    assign last          = last_reg;
    assign overlap_error = err_reg;

endmodule

FILE: tb/sv/tb.sv
module tb;

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] idx;
        logic [3:0] w;
        logic [3:0] h;
        logic       last;
        logic       err;
    } piece_t;

    // shape list, widest first, in the same order as the package
    localparam int TILE_W [sst_pkg::SHAPE_COUNT] = '{8, 8, 4, 4, 4, 4, 2, 2, 2, 1, 1, 1};
    localparam int TILE_H [sst_pkg::SHAPE_COUNT] = '{8, 4, 8, 4, 2, 1, 4, 2, 1, 4, 2, 1};

    class piece_board;
        piece_t pending_pieces[$];
        int     failures = 0;

        function int largest_fit(int w, int h);
            for (int i = 0; i < sst_pkg::SHAPE_COUNT; i++)
            begin
                if (TILE_W[i] <= w && TILE_H[i] <= h)
                    return i;
            end
            return sst_pkg::SHAPE_COUNT - 1;
        endfunction

        task flag_mismatch(string msg);
            $display("%0t: %s", $realtime, msg);
            failures++;
        endtask

        function void cut_window(logic [4:0] w_in, logic [4:0] h_in);
            int     w, h, band_y, rem_h, bh, n, s;
            int     cx, cy, cw, ch, px, py, pw, ph;
            bit     pend, held;
            piece_t p, prev;
            w = (w_in > sst_pkg::MAX_SIDE_TILES) ? sst_pkg::MAX_SIDE_TILES : int'(w_in);
            h = (h_in > sst_pkg::MAX_SIDE_TILES) ? sst_pkg::MAX_SIDE_TILES : int'(h_in);
            if (w == 0 || h == 0)
                return;
            rem_h  = h;
            band_y = 0;
            n      = 0;
            held   = 0;
            while (rem_h > 0 && n < sst_pkg::PIECE_LIMIT)
            begin
                bh   = TILE_H[largest_fit(w, rem_h)];
                cx   = 0;
                cy   = band_y;
                cw   = w;
                ch   = bh;
                pend = 0;
                while (n < sst_pkg::PIECE_LIMIT)
                begin
                    s = largest_fit(cw, ch);
                    p = '{x: 4'(cx), y: 4'(cy), idx: 4'(s), w: 4'(TILE_W[s]),
                          h: 4'(TILE_H[s]), last: 1'b0, err: 1'b0};
                    if (held)
                        pending_pieces.push_back(prev);
                    prev = p;
                    held = 1;
                    n++;
                    if (cw > TILE_W[s])
                    begin
                        // a second right remainder ends the run
                        if (pend)
                        begin
                            prev.last = 1'b1;
                            prev.err  = 1'b1;
                            pending_pieces.push_back(prev);
                            return;
                        end
                        pend = 1;
                        px   = cx + TILE_W[s];
                        py   = cy;
                        pw   = cw - TILE_W[s];
                        ph   = ch;
                    end
                    if (ch > TILE_H[s])
                    begin
                        cy += TILE_H[s];
                        ch -= TILE_H[s];
                    end
                    else if (pend)
                    begin
                        cx   = px;
                        cy   = py;
                        cw   = pw;
                        ch   = ph;
                        pend = 0;
                    end
                    else
                        break;
                end
                band_y += bh;
                rem_h  -= bh;
            end
            if (held)
            begin
                prev.last = 1'b1;
                pending_pieces.push_back(prev);
            end
        endfunction

        task match_piece(piece_t got);
            piece_t     want;
            logic [3:0] g [7];
            logic [3:0] e [7];
            string      names [7];
            if (pending_pieces.size() == 0)
            begin
                flag_mismatch($sformatf("piece with nothing expected: %p", got));
                return;
            end
            want  = pending_pieces.pop_front();
            names = '{"piece_x", "piece_y", "shape_index", "shape_width", "shape_height",
                      "last", "overlap_error"};
            g = '{got.x, got.y, got.idx, got.w, got.h, {3'b0, got.last}, {3'b0, got.err}};
            e = '{want.x, want.y, want.idx, want.w, want.h, {3'b0, want.last},
                  {3'b0, want.err}};
            for (int i = 0; i < 7; i++)
            begin
                if (g[i] !== e[i])
                    flag_mismatch($sformatf("%s: got %0d, expected %0d", names[i], g[i], e[i]));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [4:0] width_tiles;
    logic [4:0] height_tiles;
    logic       strobe;
    logic [3:0] piece_x;
    logic [3:0] piece_y;
    logic [3:0] shape_index;
    logic [3:0] shape_width;
    logic [3:0] shape_height;
    logic       last;
    logic       overlap_error;

    piece_board board = new;

    sprite_shape_rect_tiler dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .width_tiles   (width_tiles),
        .height_tiles  (height_tiles),
        .strobe        (strobe),
        .piece_x       (piece_x),
        .piece_y       (piece_y),
        .shape_index   (shape_index),
        .shape_width   (shape_width),
        .shape_height  (shape_height),
        .last          (last),
        .overlap_error (overlap_error)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.cut_window(width_tiles, height_tiles);
        if (rst_n && strobe)
            board.match_piece('{x: piece_x, y: piece_y, idx: shape_index, w: shape_width,
                                h: shape_height, last: last, err: overlap_error});
    end

    task automatic send_window(input logic [4:0] w, input logic [4:0] h, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        width_tiles  <= w;
        height_tiles <= h;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (board.pending_pieces.size() != 0)
            @(posedge clk);
    endtask

    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while (g < 24 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    // mostly in-range sizes, some zero and some saturating
    function automatic logic [4:0] random_side();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 5'd0;
        else if (r < 17)
            return 5'($urandom_range(31, 17));
        return 5'($urandom_range(sst_pkg::MAX_SIDE_TILES, 1));
    endfunction

    localparam int DIRECTED_N = 22;
    localparam logic [4:0] DIR_W [DIRECTED_N] =
        '{1, 16, 31, 0, 5, 0, 16, 1, 8, 8, 4, 3, 5, 12, 17, 7, 15, 9, 2, 16, 6, 10};
    localparam logic [4:0] DIR_H [DIRECTED_N] =
        '{1, 16, 31, 5, 0, 0, 1, 16, 8, 4, 8, 8, 6, 6, 3, 31, 15, 2, 9, 8, 3, 7};
    localparam int PHASE_IDLE [4] = '{0, 75, 19, 0};

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        width_tiles  = '0;
        height_tiles = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_window(DIR_W[i], DIR_H[i], 0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < 37; i++)
                send_window(random_side(), random_side(), idle_gap(PHASE_IDLE[ph]));
            // let the block run dry before the next phase
            drain();
        end

        repeat (8) @(posedge clk);
        while (board.pending_pieces.size() != 0)
            board.flag_mismatch($sformatf("missing piece: %p", board.pending_pieces.pop_front()));
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
